### design/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg: shared types and constants for the circle push-out resolver
// Fixed field widths, internal datapath widths, the obstacle kind codes and
// the sideband words that ride along the root and divide pipelines.
// ----------------------------------------------------------------------------
package csp_pkg;

  // default fraction bits of the Q format
  localparam int unsigned FRAC_BITS_DEF = 16;

  // field widths
  localparam int unsigned COORD_W = 32;
  localparam int unsigned RAD_W   = 31;

  // datapath widths
  localparam int unsigned DIFF_W     = 35;  // signed differences and box edges
  localparam int unsigned MAG_W      = 34;  // magnitude of a difference
  localparam int unsigned THR_W      = 33;  // radius sum or mover radius
  localparam int unsigned LO_W       = 32;  // low part of a square split
  localparam int unsigned SQ_W       = 68;  // one exact square
  localparam int unsigned DSQ_W      = 69;  // sum of two squares
  localparam int unsigned ROOT_W     = 36;  // integer root of DSQ_W bits
  localparam int unsigned SQRT_REM_W = ROOT_W + 2;
  localparam int unsigned DIV_REM_W  = ROOT_W;
  localparam int unsigned OFF_W      = 36;  // signed offset
  localparam int unsigned SUM_W      = 37;  // base plus offset

  // obstacle kind
  typedef enum logic {
    OP_CIRCLE = 1'b0,
    OP_BOX    = 1'b1
  } csp_op_e;

  // word carried alongside the root pipeline
  typedef struct packed {
    csp_op_e                   op;
    logic                      hit;
    logic signed [COORD_W-1:0] mx;
    logic signed [COORD_W-1:0] my;
    logic signed [DIFF_W-1:0]  base_x;
    logic signed [DIFF_W-1:0]  base_y;
    logic                      neg_x;
    logic                      neg_y;
    logic [MAG_W-1:0]          mag_x;
    logic [MAG_W-1:0]          mag_y;
    logic [THR_W-1:0]          thr;
  } csp_sqrt_side_t;

  // word carried alongside the divide pipeline
  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] mx;
    logic signed [COORD_W-1:0] my;
    logic signed [DIFF_W-1:0]  base_x;
    logic signed [DIFF_W-1:0]  base_y;
    logic                      neg_x;
    logic                      neg_y;
    logic                      len_zero;
    logic [THR_W-1:0]          scale;
  } csp_div_side_t;

  // clamp a signed sum into the 32-bit signed range
  function automatic logic [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic ovf;
    ovf = (v[SUM_W-1:COORD_W-1] != '0) && (v[SUM_W-1:COORD_W-1] != '1);
    if (!ovf) begin
      sat32 = v[COORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      sat32 = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      sat32 = {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

### design/csp_isqrt.sv
// ----------------------------------------------------------------------------
// csp_isqrt: pipelined integer square root
// One root bit per stage, restoring digit-by-digit method. A new radicand may
// enter every cycle; the sideband word travels with it.
// ----------------------------------------------------------------------------
module csp_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [csp_pkg::DSQ_W-1:0]    rad_i,
  input  csp_pkg::csp_sqrt_side_t      side_i,
  output logic                         valid_o,
  output logic [csp_pkg::ROOT_W-1:0]   root_o,
  output csp_pkg::csp_sqrt_side_t      side_o
);

  localparam int unsigned RW   = csp_pkg::ROOT_W;
  localparam int unsigned SW   = csp_pkg::SQRT_REM_W;
  localparam int unsigned PADW = 2 * RW;

  logic                    v_q    [RW];
  logic [PADW-1:0]         rad_q  [RW];
  logic [SW-1:0]           rem_q  [RW];
  logic [RW-1:0]           root_q [RW];
  csp_pkg::csp_sqrt_side_t side_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic                    v_in;
    logic [PADW-1:0]         rad_in;
    logic [SW-1:0]           rem_in;
    logic [RW-1:0]           root_in;
    csp_pkg::csp_sqrt_side_t side_in;
    logic [SW-1:0]           cur;
    logic [SW-1:0]           trial;
    logic                    ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rad_in  = PADW'(rad_i);
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    // bring down two radicand bits, try root*4+1
    assign cur   = {rem_in[SW-3:0], rad_in[PADW-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[k]  <= {rad_in[PADW-3:0], 2'b00};
      rem_q[k]  <= ge ? (cur - trial) : cur;
      root_q[k] <= {root_in[RW-2:0], ge};
      side_q[k] <= side_in;
    end
  end

  assign valid_o = v_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

### design/csp_div.sv
// ----------------------------------------------------------------------------
// csp_div: pipelined two-lane fraction divider
// Computes (|dx| << FRAC_BITS) / len and (|dy| << FRAC_BITS) / len, one
// quotient bit per stage. The dividend never exceeds the divisor, so the
// quotient holds FRAC_BITS+1 bits.
// ----------------------------------------------------------------------------
module csp_div #(
  parameter int unsigned FRAC_BITS = csp_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [csp_pkg::MAG_W-1:0]   num_x_i,
  input  logic [csp_pkg::MAG_W-1:0]   num_y_i,
  input  logic [csp_pkg::ROOT_W-1:0]  len_i,
  input  csp_pkg::csp_div_side_t      side_i,
  output logic                        valid_o,
  output logic [FRAC_BITS:0]          quot_x_o,
  output logic [FRAC_BITS:0]          quot_y_o,
  output csp_pkg::csp_div_side_t      side_o
);

  localparam int unsigned NS = FRAC_BITS + 1;
  localparam int unsigned QW = FRAC_BITS + 1;
  localparam int unsigned RW = csp_pkg::DIV_REM_W;
  localparam int unsigned LW = csp_pkg::ROOT_W;

  logic                   v_q     [NS];
  logic [RW-1:0]          rem_x_q [NS];
  logic [RW-1:0]          rem_y_q [NS];
  logic [QW-1:0]          q_x_q   [NS];
  logic [QW-1:0]          q_y_q   [NS];
  logic [LW-1:0]          len_q   [NS];
  csp_pkg::csp_div_side_t side_q  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic                   v_in;
    logic [RW:0]            tx;
    logic [RW:0]            ty;
    logic [QW-1:0]          qx_in;
    logic [QW-1:0]          qy_in;
    logic [LW-1:0]          len_in;
    csp_pkg::csp_div_side_t side_in;
    logic                   gx;
    logic                   gy;

    if (k == 0) begin : g_first
      // integer bit: dividend against divisor
      assign v_in    = valid_i;
      assign tx      = (RW+1)'(num_x_i);
      assign ty      = (RW+1)'(num_y_i);
      assign qx_in   = '0;
      assign qy_in   = '0;
      assign len_in  = len_i;
      assign side_in = side_i;
    end else begin : g_next
      // fraction bits: shift the partial remainder
      assign v_in    = v_q[k-1];
      assign tx      = {rem_x_q[k-1], 1'b0};
      assign ty      = {rem_y_q[k-1], 1'b0};
      assign qx_in   = q_x_q[k-1];
      assign qy_in   = q_y_q[k-1];
      assign len_in  = len_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign gx = (tx >= (RW+1)'(len_in));
    assign gy = (ty >= (RW+1)'(len_in));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_x_q[k] <= gx ? RW'(tx - (RW+1)'(len_in)) : RW'(tx);
      rem_y_q[k] <= gy ? RW'(ty - (RW+1)'(len_in)) : RW'(ty);
      q_x_q[k]   <= {qx_in[QW-2:0], gx};
      q_y_q[k]   <= {qy_in[QW-2:0], gy};
      len_q[k]   <= len_in;
      side_q[k]  <= side_in;
    end
  end

  assign valid_o  = v_q[NS-1];
  assign quot_x_o = q_x_q[NS-1];
  assign quot_y_o = q_y_q[NS-1];
  assign side_o   = side_q[NS-1];

endmodule

### design/circle_collision_push_out.sv
// Throughput: one word per cycle; busy stays low, every stage is a register
// stage with a valid bit; the 36-stage root and the FRAC_BITS+1-stage divide
// pipelines set the depth.
// Reset clears all valid bits; no result is strobed until words flow again.
// The receiver cannot stall, so results are strobed exactly once.
// ----------------------------------------------------------------------------
// circle_collision_push_out: circle and box push-out resolver, Q fixed point
// Detects overlap of a moving circle with a circle or axis-aligned box and
// returns the pushed-out centre, through a deep pipeline: setup, squares,
// compare, integer root, per-axis divide, scale multiply and saturation.
// ----------------------------------------------------------------------------
module circle_collision_push_out #(
  parameter int unsigned FRAC_BITS = csp_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              operation_i,
  input  logic signed [csp_pkg::COORD_W-1:0] mover_x_i,
  input  logic signed [csp_pkg::COORD_W-1:0] mover_y_i,
  input  logic [csp_pkg::RAD_W-1:0]         mover_radius_i,
  input  logic signed [csp_pkg::COORD_W-1:0] obstacle_x_i,
  input  logic signed [csp_pkg::COORD_W-1:0] obstacle_y_i,
  input  logic [csp_pkg::RAD_W-1:0]         obstacle_radius_i,
  input  logic [csp_pkg::RAD_W-1:0]         obstacle_width_i,
  input  logic [csp_pkg::RAD_W-1:0]         obstacle_height_i,
  output logic                              valid_o,
  output logic                              hit_o,
  output logic signed [csp_pkg::COORD_W-1:0] new_x_o,
  output logic signed [csp_pkg::COORD_W-1:0] new_y_o
);

  localparam int unsigned CW   = csp_pkg::COORD_W;
  localparam int unsigned DW   = csp_pkg::DIFF_W;
  localparam int unsigned MW   = csp_pkg::MAG_W;
  localparam int unsigned TW   = csp_pkg::THR_W;
  localparam int unsigned LO   = csp_pkg::LO_W;
  localparam int unsigned HW   = MW - LO;
  localparam int unsigned SQW  = csp_pkg::SQ_W;
  localparam int unsigned DSW  = csp_pkg::DSQ_W;
  localparam int unsigned QW   = FRAC_BITS + 1;
  localparam int unsigned PW   = QW + TW;
  localparam int unsigned OW   = csp_pkg::OFF_W;
  localparam int unsigned SMW  = csp_pkg::SUM_W;
  localparam int unsigned LAT  = FRAC_BITS + 43;  // accepting edge to result edge

  // never holds off a word
  assign busy = 1'b0;

  // ------------------------------------------------------------------ stage 1
  // differences, box clamp, threshold select
  logic signed [DW-1:0] mx_e, my_e, ox_e, oy_e, hw_e, hh_e;
  logic signed [DW-1:0] left, right, bottom, top_e, tx, ty;
  logic signed [DW-1:0] dx_d, dy_d, bx_d, by_d;
  logic [TW-1:0]        thr_d;
  logic                 is_box;

  always_comb begin
    mx_e   = {{(DW-CW){mover_x_i[CW-1]}}, mover_x_i};
    my_e   = {{(DW-CW){mover_y_i[CW-1]}}, mover_y_i};
    ox_e   = {{(DW-CW){obstacle_x_i[CW-1]}}, obstacle_x_i};
    oy_e   = {{(DW-CW){obstacle_y_i[CW-1]}}, obstacle_y_i};
    hw_e   = DW'(obstacle_width_i[csp_pkg::RAD_W-1:1]);
    hh_e   = DW'(obstacle_height_i[csp_pkg::RAD_W-1:1]);
    left   = ox_e - hw_e;
    right  = ox_e + hw_e;
    bottom = oy_e - hh_e;
    top_e  = oy_e + hh_e;
    tx     = mx_e;
    if (mx_e < left) begin
      tx = left;
    end else if (mx_e > right) begin
      tx = right;
    end
    ty = my_e;
    if (my_e > top_e) begin
      ty = top_e;
    end else if (my_e < bottom) begin
      ty = bottom;
    end
    is_box = (operation_i == csp_pkg::OP_BOX);
    if (is_box) begin
      dx_d  = mx_e - tx;
      dy_d  = my_e - ty;
      bx_d  = tx;
      by_d  = ty;
      thr_d = TW'(mover_radius_i);
    end else begin
      dx_d  = mx_e - ox_e;
      dy_d  = my_e - oy_e;
      bx_d  = mx_e;
      by_d  = my_e;
      thr_d = TW'(mover_radius_i) + TW'(obstacle_radius_i);
    end
  end

  logic                 v1_q;
  csp_pkg::csp_op_e     op1_q;
  logic signed [CW-1:0] mx1_q, my1_q;
  logic signed [DW-1:0] bx1_q, by1_q, dx1_q, dy1_q;
  logic [TW-1:0]        thr1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q  <= csp_pkg::csp_op_e'(operation_i);
    mx1_q  <= mover_x_i;
    my1_q  <= mover_y_i;
    bx1_q  <= bx_d;
    by1_q  <= by_d;
    dx1_q  <= dx_d;
    dy1_q  <= dy_d;
    thr1_q <= thr_d;
  end

  // ------------------------------------------------------------------ stage 2
  // magnitudes and split partial products of the three squares
  logic [MW-1:0] magx, magy, magr;

  assign magx = dx1_q[DW-1] ? MW'(-dx1_q) : MW'(dx1_q);
  assign magy = dy1_q[DW-1] ? MW'(-dy1_q) : MW'(dy1_q);
  assign magr = MW'(thr1_q);

  logic                 v2_q;
  csp_pkg::csp_op_e     op2_q;
  logic signed [CW-1:0] mx2_q, my2_q;
  logic signed [DW-1:0] bx2_q, by2_q;
  logic                 nx2_q, ny2_q;
  logic [MW-1:0]        magx2_q, magy2_q;
  logic [TW-1:0]        thr2_q;
  logic [2*LO-1:0]      llx_q, lly_q, llr_q;
  logic [LO+HW-1:0]     lhx_q, lhy_q, lhr_q;
  logic [2*HW-1:0]      hhx_q, hhy_q, hhr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op2_q   <= op1_q;
    mx2_q   <= mx1_q;
    my2_q   <= my1_q;
    bx2_q   <= bx1_q;
    by2_q   <= by1_q;
    nx2_q   <= dx1_q[DW-1];
    ny2_q   <= dy1_q[DW-1];
    magx2_q <= magx;
    magy2_q <= magy;
    thr2_q  <= thr1_q;
    llx_q   <= (2*LO)'(magx[LO-1:0]) * (2*LO)'(magx[LO-1:0]);
    lly_q   <= (2*LO)'(magy[LO-1:0]) * (2*LO)'(magy[LO-1:0]);
    llr_q   <= (2*LO)'(magr[LO-1:0]) * (2*LO)'(magr[LO-1:0]);
    lhx_q   <= (LO+HW)'(magx[LO-1:0]) * (LO+HW)'(magx[MW-1:LO]);
    lhy_q   <= (LO+HW)'(magy[LO-1:0]) * (LO+HW)'(magy[MW-1:LO]);
    lhr_q   <= (LO+HW)'(magr[LO-1:0]) * (LO+HW)'(magr[MW-1:LO]);
    hhx_q   <= (2*HW)'(magx[MW-1:LO]) * (2*HW)'(magx[MW-1:LO]);
    hhy_q   <= (2*HW)'(magy[MW-1:LO]) * (2*HW)'(magy[MW-1:LO]);
    hhr_q   <= (2*HW)'(magr[MW-1:LO]) * (2*HW)'(magr[MW-1:LO]);
  end

  // ------------------------------------------------------------------ stage 3
  // assemble exact squares: ll + 2*lh*2^LO + hh*2^(2*LO)
  logic                 v3_q;
  csp_pkg::csp_op_e     op3_q;
  logic signed [CW-1:0] mx3_q, my3_q;
  logic signed [DW-1:0] bx3_q, by3_q;
  logic                 nx3_q, ny3_q;
  logic [MW-1:0]        magx3_q, magy3_q;
  logic [TW-1:0]        thr3_q;
  logic [SQW-1:0]       sqx_q, sqy_q, sqr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op3_q   <= op2_q;
    mx3_q   <= mx2_q;
    my3_q   <= my2_q;
    bx3_q   <= bx2_q;
    by3_q   <= by2_q;
    nx3_q   <= nx2_q;
    ny3_q   <= ny2_q;
    magx3_q <= magx2_q;
    magy3_q <= magy2_q;
    thr3_q  <= thr2_q;
    sqx_q   <= SQW'(llx_q) + (SQW'(lhx_q) << (LO + 1)) + (SQW'(hhx_q) << (2 * LO));
    sqy_q   <= SQW'(lly_q) + (SQW'(lhy_q) << (LO + 1)) + (SQW'(hhy_q) << (2 * LO));
    sqr_q   <= SQW'(llr_q) + (SQW'(lhr_q) << (LO + 1)) + (SQW'(hhr_q) << (2 * LO));
  end

  // ------------------------------------------------------------------ stage 4
  // squared distance and hit test (strict for circles, inclusive for boxes)
  logic [DSW-1:0] dsq;
  logic           hit4;

  assign dsq  = DSW'(sqx_q) + DSW'(sqy_q);
  assign hit4 = (op3_q == csp_pkg::OP_BOX) ? (dsq <= DSW'(sqr_q)) : (DSW'(sqr_q) > dsq);

  logic                    v4_q;
  logic [DSW-1:0]          dsq4_q;
  csp_pkg::csp_sqrt_side_t side4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dsq4_q         <= dsq;
    side4_q.op     <= op3_q;
    side4_q.hit    <= hit4;
    side4_q.mx     <= mx3_q;
    side4_q.my     <= my3_q;
    side4_q.base_x <= bx3_q;
    side4_q.base_y <= by3_q;
    side4_q.neg_x  <= nx3_q;
    side4_q.neg_y  <= ny3_q;
    side4_q.mag_x  <= magx3_q;
    side4_q.mag_y  <= magy3_q;
    side4_q.thr    <= thr3_q;
  end

  // ------------------------------------------------------------------ root
  logic                         vs;
  logic [csp_pkg::ROOT_W-1:0]   len;
  csp_pkg::csp_sqrt_side_t      ss;

  csp_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .rad_i   (dsq4_q),
    .side_i  (side4_q),
    .valid_o (vs),
    .root_o  (len),
    .side_o  (ss)
  );

  // push distance: overlap for circles, mover radius for boxes
  csp_pkg::csp_div_side_t dside;

  always_comb begin
    dside.hit      = ss.hit;
    dside.mx       = ss.mx;
    dside.my       = ss.my;
    dside.base_x   = ss.base_x;
    dside.base_y   = ss.base_y;
    dside.neg_x    = ss.neg_x;
    dside.neg_y    = ss.neg_y;
    dside.len_zero = (len == '0);
    if (ss.op == csp_pkg::OP_BOX) begin
      dside.scale = ss.thr;
    end else if (csp_pkg::ROOT_W'(ss.thr) > len) begin
      dside.scale = TW'(csp_pkg::ROOT_W'(ss.thr) - len);
    end else begin
      dside.scale = '0;
    end
  end

  // ------------------------------------------------------------------ divide
  logic                   vd;
  logic [QW-1:0]          ux, uy;
  csp_pkg::csp_div_side_t ds;

  csp_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (vs),
    .num_x_i  (ss.mag_x),
    .num_y_i  (ss.mag_y),
    .len_i    (len),
    .side_i   (dside),
    .valid_o  (vd),
    .quot_x_o (ux),
    .quot_y_o (uy),
    .side_o   (ds)
  );

  // ------------------------------------------------------------------ scale
  // unit component times push distance; zero direction gives zero
  logic                   vm_q;
  logic [PW-1:0]          px_q, py_q;
  csp_pkg::csp_div_side_t sm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else begin
      vm_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= ds.len_zero ? '0 : PW'(ux) * PW'(ds.scale);
    py_q <= ds.len_zero ? '0 : PW'(uy) * PW'(ds.scale);
    sm_q <= ds;
  end

  // ------------------------------------------------------------------ output
  // signed offset toward zero, add to base, saturate
  logic [MW-1:0]         offx, offy;
  logic signed [OW-1:0]  sox, soy;
  logic signed [SMW-1:0] sumx, sumy;

  always_comb begin
    offx = px_q[PW-1:FRAC_BITS];
    offy = py_q[PW-1:FRAC_BITS];
    sox  = sm_q.neg_x ? -OW'(offx) : OW'(offx);
    soy  = sm_q.neg_y ? -OW'(offy) : OW'(offy);
    sumx = {{(SMW-DW){sm_q.base_x[DW-1]}}, sm_q.base_x} + {{(SMW-OW){sox[OW-1]}}, sox};
    sumy = {{(SMW-DW){sm_q.base_y[DW-1]}}, sm_q.base_y} + {{(SMW-OW){soy[OW-1]}}, soy};
  end

  logic                 vo_q;
  logic                 hit_q;
  logic signed [CW-1:0] nx_q, ny_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= sm_q.hit;
    nx_q  <= sm_q.hit ? csp_pkg::sat32(sumx) : sm_q.mx;
    ny_q  <= sm_q.hit ? csp_pkg::sat32(sumy) : sm_q.my;
  end

  assign valid_o = vo_q;
  assign hit_o   = hit_q;
  assign new_x_o = nx_q;
  assign new_y_o = ny_q;

  // ------------------------------------------------------------------ checks
  // a strobe always traces back to an accepted word
  a_strobe_has_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start, LAT))
    else $error("result strobe without an accepted word");

  // a miss returns the mover centre untouched
  a_miss_keeps_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !hit_o |-> (new_x_o == $past(mover_x_i, LAT)) &&
                          (new_y_o == $past(mover_y_i, LAT)))
    else $error("miss altered the mover position");

  // two zero-radius circles never collide
  a_zero_radii_miss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && $past((operation_i == csp_pkg::OP_CIRCLE) && (mover_radius_i == '0) &&
                     (obstacle_radius_i == '0), LAT) |-> !hit_o)
    else $error("hit reported for zero radii");

endmodule
